>>> rtl/csv_field_boundary_scanner_unit_macros.svh
// Assertion macros used by the scanner core.
`ifndef CSV_FIELD_BOUNDARY_SCANNER_UNIT_MACROS_SVH
`define CSV_FIELD_BOUNDARY_SCANNER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CSVFB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CSVFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/csvfb_pkg.sv
`timescale 1ns / 1ps

package csvfb_pkg;

   // Result field widths.
   localparam int unsigned COL_OUT_W = 11;
   localparam int unsigned ROW_OUT_W = 24;

   // Special characters.
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;

   // Configuration register defaults.
   localparam logic [7:0] DELIMITER_RESET = 8'd44;
   localparam logic       BACKSLASH_RESET = 1'b1;
   localparam logic       DOUBLED_RESET   = 1'b0;
   localparam logic       SQUOTE_RESET    = 1'b1;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_DELIMITER  = 2'd0,
      CSR_BACKSLASH  = 2'd1,
      CSR_DOUBLED_DQ = 2'd2,
      CSR_SQUOTE     = 2'd3
   } csr_index_type;

   // Boundary kinds reported with each byte.
   typedef enum logic [1:0] {
      BK_NONE    = 2'd0,
      BK_DELIM   = 2'd1,
      BK_NEWLINE = 2'd2,
      BK_END     = 2'd3
   } boundary_kind_type;

   typedef struct packed {
      logic [7:0] delimiter_char;
      logic       backslash_escape_on;
      logic       doubled_quote_escape_on;
      logic       single_quote_nest_on;
   } cfg_type;

   typedef struct packed {
      boundary_kind_type      boundary_kind;
      logic [COL_OUT_W-1:0]   column_index;
      logic [ROW_OUT_W-1:0]   row_index;
      logic [COL_OUT_W-1:0]   column_count;
      logic                   width_error;
      logic                   totals_valid;
   } rsp_type;

endpackage

>>> rtl/csvfb_cfg_regs.sv
`timescale 1ns / 1ps

module csvfb_cfg_regs
   import csvfb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register index and update the addressed field.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DELIMITER:  cfg_in.delimiter_char          = csr_write_data;
            CSR_BACKSLASH:  cfg_in.backslash_escape_on     = csr_write_data[0];
            CSR_DOUBLED_DQ: cfg_in.doubled_quote_escape_on = csr_write_data[0];
            CSR_SQUOTE:     cfg_in.single_quote_nest_on    = csr_write_data[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delimiter_char          <= DELIMITER_RESET;
         cfg_ff.backslash_escape_on     <= BACKSLASH_RESET;
         cfg_ff.doubled_quote_escape_on <= DOUBLED_RESET;
         cfg_ff.single_quote_nest_on    <= SQUOTE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/csvfb_scan_core.sv
`timescale 1ns / 1ps

`include "csv_field_boundary_scanner_unit_macros.svh"

module csvfb_scan_core
   import csvfb_pkg::*;
#(
   parameter int unsigned MAX_COLUMNS = 1024,
   parameter int unsigned ROW_BITS    = 24
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic [7:0] lookahead_byte,
   input  logic       last_byte,
   output rsp_type    result
);

   localparam int unsigned ColW = $clog2(MAX_COLUMNS + 1);
   localparam logic [ColW-1:0] ColMax = ColW'(MAX_COLUMNS);
   localparam logic [ROW_BITS-1:0] RowMax = {ROW_BITS{1'b1}};

   logic                dq_ff, dq_in;
   logic                sq_ff, sq_in;
   logic [7:0]          prev_ff, prev_in;
   logic [ColW-1:0]     col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [ColW-1:0]     cpr_ff, cpr_in;
   logic                err_ff, err_in;

   boundary_kind_type   kind;
   logic                dq_upd, sq_upd;
   logic                escaped, quoted, close_row;
   logic [ColW-1:0]     col_inc, col_upd, cpr_upd;
   logic [ROW_BITS-1:0] row_upd;
   logic                err_upd;
   logic [15:0]         col_wide, cpr_wide;
   logic [31:0]         row_wide;

   assign escaped = (prev_ff == CH_BACKSLASH) && cfg.backslash_escape_on;
   assign quoted  = dq_ff || sq_ff;

   // Classify the byte and toggle quote state. Delimiter wins over quotes.
   always_comb begin
      kind   = BK_NONE;
      dq_upd = dq_ff;
      sq_upd = sq_ff;
      priority if (data_byte == cfg.delimiter_char) begin
         if (!escaped && !quoted) kind = BK_DELIM;
      end else if (data_byte == CH_DQUOTE) begin
         if (!sq_ff && !escaped &&
             !(cfg.doubled_quote_escape_on &&
               (prev_ff == CH_DQUOTE || lookahead_byte == CH_DQUOTE))) begin
            dq_upd = !dq_ff;
         end
      end else if (data_byte == CH_SQUOTE && cfg.single_quote_nest_on) begin
         if (!escaped) sq_upd = !sq_ff;
      end else if (data_byte == CH_NEWLINE) begin
         if (!quoted) kind = BK_NEWLINE;
      end else begin
         kind = BK_NONE;
      end
      if (kind == BK_NONE && last_byte) kind = BK_END;
   end

   // Column and row bookkeeping, saturating.
   assign close_row = (kind == BK_NEWLINE) || (kind == BK_END) ||
                      (kind == BK_DELIM && last_byte);
   assign col_inc   = (col_ff >= ColMax) ? ColMax : col_ff + 1'b1;

   always_comb begin
      col_upd = col_ff;
      cpr_upd = cpr_ff;
      err_upd = err_ff;
      row_upd = row_ff;
      if (close_row) begin
         col_upd = '0;
         if (row_ff == '0) begin
            cpr_upd = col_inc;
         end else if (col_inc != cpr_ff) begin
            err_upd = 1'b1;
         end
         if (row_ff != RowMax) row_upd = row_ff + 1'b1;
      end else if (kind == BK_DELIM) begin
         col_upd = col_inc;
      end
   end

   // Next state: a boundary clears quotes and the previous byte, and the
   // final byte of a buffer returns everything to its reset value.
   always_comb begin
      dq_in   = dq_ff;
      sq_in   = sq_ff;
      prev_in = prev_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      cpr_in  = cpr_ff;
      err_in  = err_ff;
      if (step) begin
         if (last_byte) begin
            dq_in   = 1'b0;
            sq_in   = 1'b0;
            prev_in = '0;
            col_in  = '0;
            row_in  = '0;
            cpr_in  = '0;
            err_in  = 1'b0;
         end else begin
            dq_in   = (kind == BK_NONE) ? dq_upd : 1'b0;
            sq_in   = (kind == BK_NONE) ? sq_upd : 1'b0;
            prev_in = (kind == BK_NONE) ? data_byte : 8'h00;
            col_in  = col_upd;
            row_in  = row_upd;
            cpr_in  = cpr_upd;
            err_in  = err_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dq_ff   <= 1'b0;
         sq_ff   <= 1'b0;
         prev_ff <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
         cpr_ff  <= '0;
         err_ff  <= 1'b0;
      end else begin
         dq_ff   <= dq_in;
         sq_ff   <= sq_in;
         prev_ff <= prev_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         cpr_ff  <= cpr_in;
         err_ff  <= err_in;
      end
   end

   // Fit the counters to the result field widths.
   assign col_wide = 16'(col_ff);
   assign cpr_wide = 16'(cpr_upd);
   assign row_wide = 32'(row_upd);

   assign result.boundary_kind = kind;
   assign result.column_index  = col_wide[COL_OUT_W-1:0];
   assign result.row_index     = row_wide[ROW_OUT_W-1:0];
   assign result.column_count  = cpr_wide[COL_OUT_W-1:0];
   assign result.width_error   = err_upd;
   assign result.totals_valid  = last_byte;

   `CSVFB_ASSERT_NEXT(a_last_clears, clock, reset, step && last_byte, (row_ff == '0) && (col_ff == '0) && !err_ff && !dq_ff && !sq_ff, "state not cleared after final byte")
   `CSVFB_ASSERT_NEXT(a_boundary_clears_quotes, clock, reset, step && (kind != BK_NONE), !dq_ff && !sq_ff && (prev_ff == 8'h00), "quote state kept across a boundary")
   `CSVFB_ASSERT_NEXT(a_error_sticky, clock, reset, err_ff && !(step && last_byte), err_ff, "width error dropped inside a buffer")
   `CSVFB_ASSERT_NOW(a_col_saturates, clock, reset, 1'b1, col_ff <= ColMax, "column counter past its limit")

endmodule

>>> rtl/csv_field_boundary_scanner_unit.sv
`timescale 1ns / 1ps
// Each byte passes the input register, the scan core and the result register.
// Throughput: one byte per cycle unless results stall.
// Both the input register and the result register may hold a beat, so a stalled
// result does not stop the input side until both are full.
// Reset clears all scan state and loads the configuration register defaults.

module csv_field_boundary_scanner_unit
   import csvfb_pkg::*;
#(
   parameter int unsigned MAX_COLUMNS = 1024,
   parameter int unsigned ROW_BITS    = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   // Configuration write port.
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [7:0]           csr_write_data,
   // Input bytes.
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic [7:0]           req_lookahead_byte,
   input  logic                 req_last_byte,
   // Results.
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_boundary_kind,
   output logic [COL_OUT_W-1:0] rsp_column_index,
   output logic [ROW_OUT_W-1:0] rsp_row_index,
   output logic [COL_OUT_W-1:0] rsp_column_count,
   output logic                 rsp_width_error,
   output logic                 rsp_totals_valid
);

   cfg_type    cfg;
   rsp_type    core_result;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff, in_data_in;
   logic [7:0] in_la_ff, in_la_in;
   logic       in_last_ff, in_last_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;

   logic       out_free, step, req_fire;

   csvfb_cfg_regs u_cfg_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // The core processes the held beat whenever the result register can take it.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   csvfb_scan_core #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .ROW_BITS    (ROW_BITS)
   ) u_scan_core (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .step           (step),
      .data_byte      (in_data_ff),
      .lookahead_byte (in_la_ff),
      .last_byte      (in_last_ff),
      .result         (core_result)
   );

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      in_la_in    = in_la_ff;
      in_last_in  = in_last_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data_byte;
         in_la_in    = req_lookahead_byte;
         in_last_in  = req_last_byte;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (step) begin
         out_valid_in = 1'b1;
         out_in       = core_result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      in_la_ff   <= in_la_in;
      in_last_ff <= in_last_in;
      out_ff     <= out_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_boundary_kind = out_ff.boundary_kind;
   assign rsp_column_index  = out_ff.column_index;
   assign rsp_row_index     = out_ff.row_index;
   assign rsp_column_count  = out_ff.column_count;
   assign rsp_width_error   = out_ff.width_error;
   assign rsp_totals_valid  = out_ff.totals_valid;

endmodule

>>> tb/csv_scan_checker.sv
`timescale 1ns / 1ps

module csv_scan_checker
   import csvfb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [7:0]           csr_write_data,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic [7:0]           req_lookahead_byte,
   input  logic                 req_last_byte,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [1:0]           rsp_boundary_kind,
   input  logic [COL_OUT_W-1:0] rsp_column_index,
   input  logic [ROW_OUT_W-1:0] rsp_row_index,
   input  logic [COL_OUT_W-1:0] rsp_column_count,
   input  logic                 rsp_width_error,
   input  logic                 rsp_totals_valid,
   output int unsigned          mismatch_count,
   output int unsigned          scans_outstanding
);

   localparam logic [COL_OUT_W-1:0] COLUMN_LIMIT = 11'd1024;
   localparam logic [ROW_OUT_W-1:0] ROW_LIMIT = '1;
   localparam int unsigned MISMATCH_REPORTS = 10;

   // Scanner settings and state as this checker tracks them.
   cfg_type              scan_cfg;
   logic                 in_dquote;
   logic                 in_squote;
   logic [7:0]           prior_byte;
   logic [COL_OUT_W-1:0] column_now;
   logic [ROW_OUT_W-1:0] row_now;
   logic [COL_OUT_W-1:0] columns_fixed;
   logic                 width_bad;

   rsp_type     scans_due[$];
   int unsigned misses = 0;

   function automatic logic [COL_OUT_W-1:0] next_column(input logic [COL_OUT_W-1:0] c);
      return (c >= COLUMN_LIMIT) ? COLUMN_LIMIT : c + 1'b1;
   endfunction

   function automatic void clear_scan_state();
      in_dquote     = 1'b0;
      in_squote     = 1'b0;
      prior_byte    = 8'h00;
      column_now    = '0;
      row_now       = '0;
      columns_fixed = '0;
      width_bad     = 1'b0;
   endfunction

   // Advances the tracked state by one byte and returns the result it should produce.
   function automatic rsp_type scan_byte(input logic [7:0] cur, input logic [7:0] ahead,
                                         input logic is_last);
      rsp_type              r;
      logic                 escaped;
      logic                 quoted;
      boundary_kind_type    kind;
      logic [COL_OUT_W-1:0] col_seen;
      logic [COL_OUT_W-1:0] width;

      escaped  = (prior_byte == CH_BACKSLASH) && scan_cfg.backslash_escape_on;
      quoted   = in_dquote || in_squote;
      kind     = BK_NONE;
      col_seen = column_now;

      // The delimiter test wins over every special character.
      if (cur == scan_cfg.delimiter_char) begin
         if (!escaped && !quoted) kind = BK_DELIM;
      end else if (cur == CH_DQUOTE) begin
         if (!in_squote && !escaped &&
             !(scan_cfg.doubled_quote_escape_on &&
               (prior_byte == CH_DQUOTE || ahead == CH_DQUOTE)))
            in_dquote = ~in_dquote;
      end else if (cur == CH_SQUOTE && scan_cfg.single_quote_nest_on) begin
         if (!escaped) in_squote = ~in_squote;
      end else if (cur == CH_NEWLINE) begin
         if (!quoted) kind = BK_NEWLINE;
      end

      if (kind == BK_NONE && is_last) kind = BK_END;

      // A delimiter moves to the next column unless it is the final byte,
      // in which case it closes the row like a newline.
      if (kind == BK_DELIM && !is_last) begin
         column_now = next_column(column_now);
      end else if (kind != BK_NONE) begin
         width = next_column(column_now);
         if (row_now == '0) columns_fixed = width;
         else if (width != columns_fixed) width_bad = 1'b1;
         if (row_now != ROW_LIMIT) row_now = row_now + 1'b1;
         column_now = '0;
      end

      if (kind != BK_NONE) begin
         in_dquote  = 1'b0;
         in_squote  = 1'b0;
         prior_byte = 8'h00;
      end else begin
         prior_byte = cur;
      end

      r.boundary_kind = kind;
      r.column_index  = col_seen;
      r.row_index     = row_now;
      r.column_count  = columns_fixed;
      r.width_error   = width_bad;
      r.totals_valid  = is_last;

      if (is_last) clear_scan_state();
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         misses++;
         if (misses <= MISMATCH_REPORTS)
            $display("%s mismatch: expected %0d, got %0d", name, want, got);
      end
   endtask

   // Settings, predictions and comparisons, all sampled at the rising edge.
   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         scan_cfg = '{DELIMITER_RESET, BACKSLASH_RESET, DOUBLED_RESET, SQUOTE_RESET};
         clear_scan_state();
         scans_due.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_DELIMITER:  scan_cfg.delimiter_char = csr_write_data;
               CSR_BACKSLASH:  scan_cfg.backslash_escape_on = csr_write_data[0];
               CSR_DOUBLED_DQ: scan_cfg.doubled_quote_escape_on = csr_write_data[0];
               CSR_SQUOTE:     scan_cfg.single_quote_nest_on = csr_write_data[0];
               default: ;
            endcase
         end

         // A result beat always belongs to an older byte, so compare first.
         if (rsp_valid && rsp_ready) begin
            if (scans_due.size() == 0) begin
               misses++;
               if (misses <= MISMATCH_REPORTS)
                  $display("result beat with no byte awaiting it: boundary_kind %0d",
                           rsp_boundary_kind);
            end else begin
               due = scans_due.pop_front();
               check_field("boundary_kind", due.boundary_kind, rsp_boundary_kind);
               check_field("column_index", due.column_index, rsp_column_index);
               check_field("row_index", due.row_index, rsp_row_index);
               check_field("column_count", due.column_count, rsp_column_count);
               check_field("width_error", due.width_error, rsp_width_error);
               check_field("totals_valid", due.totals_valid, rsp_totals_valid);
            end
         end

         if (req_valid && req_ready)
            scans_due.push_back(scan_byte(req_data_byte, req_lookahead_byte, req_last_byte));
      end
      mismatch_count    <= misses;
      scans_outstanding <= scans_due.size();
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import csvfb_pkg::*;

   localparam int unsigned STALL_LIMIT     = 1000;
   localparam int unsigned BYTES_PER_PHASE = 30;
   localparam int unsigned LONG_ROW_DELIMS = 1030;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write_enable;
   logic [1:0]           csr_index;
   logic [7:0]           csr_write_data;
   logic                 req_valid;
   logic                 req_ready;
   logic [7:0]           req_data_byte;
   logic [7:0]           req_lookahead_byte;
   logic                 req_last_byte;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [1:0]           rsp_boundary_kind;
   logic [COL_OUT_W-1:0] rsp_column_index;
   logic [ROW_OUT_W-1:0] rsp_row_index;
   logic [COL_OUT_W-1:0] rsp_column_count;
   logic                 rsp_width_error;
   logic                 rsp_totals_valid;

   int unsigned mismatch_count;
   int unsigned scans_outstanding;
   int unsigned quiet_cycles = 0;
   int unsigned bytes_sent = 0;
   bit          sender_pauses = 1'b1;
   bit          sink_stalls = 1'b1;
   cfg_type     text_cfg = '{DELIMITER_RESET, BACKSLASH_RESET, DOUBLED_RESET, SQUOTE_RESET};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   csv_field_boundary_scanner_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_lookahead_byte (req_lookahead_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_boundary_kind  (rsp_boundary_kind),
      .rsp_column_index   (rsp_column_index),
      .rsp_row_index      (rsp_row_index),
      .rsp_column_count   (rsp_column_count),
      .rsp_width_error    (rsp_width_error),
      .rsp_totals_valid   (rsp_totals_valid)
   );

   csv_scan_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_lookahead_byte (req_lookahead_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_boundary_kind  (rsp_boundary_kind),
      .rsp_column_index   (rsp_column_index),
      .rsp_row_index      (rsp_row_index),
      .rsp_column_count   (rsp_column_count),
      .rsp_width_error    (rsp_width_error),
      .rsp_totals_valid   (rsp_totals_valid),
      .mismatch_count     (mismatch_count),
      .scans_outstanding  (scans_outstanding)
   );

   // Result side: ready drops in random bursts while stalls are enabled.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_stalls && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: too many cycles in a row without any accepted beat ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Presents one byte beat and returns at the falling edge after it is taken.
   task automatic send_byte(input logic [7:0] cur, input logic [7:0] ahead, input logic is_last);
      if (sender_pauses && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_data_byte      <= cur;
      req_lookahead_byte <= ahead;
      req_last_byte      <= is_last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(input string s, input bit ends_buffer);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], (i + 1 < s.len()) ? s[i + 1] : 8'h00,
                   ends_buffer && (i == s.len() - 1));
   endtask

   // Stops sending and waits until every result has come out.
   task automatic drain();
      req_valid <= 1'b0;
      while (scans_outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic apply_settings(input cfg_type c);
      drain();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_DELIMITER;
      csr_write_data   <= c.delimiter_char;
      @(negedge clock);
      csr_index      <= CSR_BACKSLASH;
      csr_write_data <= {7'd0, c.backslash_escape_on};
      @(negedge clock);
      csr_index      <= CSR_DOUBLED_DQ;
      csr_write_data <= {7'd0, c.doubled_quote_escape_on};
      @(negedge clock);
      csr_index      <= CSR_SQUOTE;
      csr_write_data <= {7'd0, c.single_quote_nest_on};
      @(negedge clock);
      csr_write_enable <= 1'b0;
      text_cfg = c;
   endtask

   // Builds a small CSV buffer of rows and fields with random content, or
   // now and then plain noise, and streams it out byte by byte.
   task automatic send_random_buffer();
      logic [7:0]  text[$];
      int unsigned rows;
      int unsigned cols;
      int unsigned row_cols;
      bit          broken;

      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 12))
            send_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      $urandom_range(0, 11) == 0);
         return;
      end

      rows = $urandom_range(1, 4);
      cols = $urandom_range(1, 5);
      for (int r = 0; r < rows; r++) begin
         // Most rows keep the buffer's width; a few break it.
         row_cols = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : cols;
         for (int c = 0; c < row_cols; c++) begin
            if (c != 0) text.push_back(text_cfg.delimiter_char);
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  repeat ($urandom_range(0, 4))
                     text.push_back(8'h61 + 8'($urandom_range(0, 25)));
               end
               4, 5, 6: begin
                  // Protected field with delimiters, newlines and quotes inside.
                  text.push_back(($urandom_range(0, 2) == 0) ? CH_SQUOTE : CH_DQUOTE);
                  repeat ($urandom_range(0, 4)) begin
                     case ($urandom_range(0, 5))
                        0: text.push_back(8'h61 + 8'($urandom_range(0, 25)));
                        1: text.push_back(text_cfg.delimiter_char);
                        2: text.push_back(CH_NEWLINE);
                        3: text.push_back(CH_DQUOTE);
                        4: text.push_back(CH_SQUOTE);
                        default: text.push_back(CH_BACKSLASH);
                     endcase
                  end
                  text.push_back(($urandom_range(0, 2) == 0) ? CH_SQUOTE : CH_DQUOTE);
               end
               7: begin
                  text.push_back(CH_BACKSLASH);
                  case ($urandom_range(0, 3))
                     0: text.push_back(text_cfg.delimiter_char);
                     1: text.push_back(CH_DQUOTE);
                     2: text.push_back(CH_SQUOTE);
                     default: text.push_back(CH_BACKSLASH);
                  endcase
               end
               default: begin
                  repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
               end
            endcase
         end
         if (r + 1 < rows || $urandom_range(0, 1) == 0) text.push_back(CH_NEWLINE);
      end

      // A broken buffer ends without its end mark and with a stray lookahead.
      broken = ($urandom_range(0, 7) == 0);
      foreach (text[i])
         send_byte(text[i],
                   (i + 1 < text.size()) ? text[i + 1] :
                      (broken ? 8'($urandom_range(0, 255)) : 8'h00),
                   !broken && (i == text.size() - 1));
   endtask

   initial begin
      cfg_type     next_cfg;
      int unsigned target;

      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_DELIMITER;
      csr_write_data     = 8'h00;
      req_valid          = 1'b0;
      req_data_byte      = 8'h00;
      req_lookahead_byte = 8'h00;
      req_last_byte      = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Byte extremes, plain, escaped and protected delimiters, a double quote
      // inside single quotes; the newline fixes a width of two.
      send_byte(8'h00, 8'hFF, 1'b0);
      send_byte(8'hFF, 8'h2C, 1'b0);
      send_text(",\\,\",\"'\"'\n", 1'b0);
      // Single quote inside double quotes, a protected newline, an escaped
      // double quote; the row ends at the last byte with a width error.
      send_text("\"'\n'\"\\\"x", 1'b1);
      // A delimiter as the last byte of a fresh buffer.
      send_text(",", 1'b1);

      // Doubled double quotes, and a newline as the last byte.
      next_cfg = '{DELIMITER_RESET, 1'b1, 1'b1, 1'b1};
      apply_settings(next_cfg);
      send_text("a\"\"b\n", 1'b1);

      // A row long enough for the column count to saturate, then a short one.
      repeat (LONG_ROW_DELIMS)
         send_byte(text_cfg.delimiter_char, text_cfg.delimiter_char, 1'b0);
      send_text("\na\n", 1'b0);

      // Random buffers under several settings; the final phase runs without idling.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       next_cfg = '{DELIMITER_RESET, 1'b1, 1'b0, 1'b1};
            1:       next_cfg = '{8'h00, 1'b0, 1'b1, 1'b0};
            2:       next_cfg = '{8'hFF, 1'b1, 1'b1, 1'b1};
            3:       next_cfg = '{CH_DQUOTE, 1'b1, 1'b0, 1'b1};
            4:       next_cfg = '{CH_BACKSLASH, 1'b1, 1'b1, 1'b0};
            default: next_cfg = '{8'h3B, 1'b0, 1'b0, 1'b1};
         endcase
         apply_settings(next_cfg);
         sender_pauses = (phase != 5) && (phase != 2);
         sink_stalls   = (phase != 5) && (phase != 1);
         target = bytes_sent + BYTES_PER_PHASE;
         while (bytes_sent < target) send_random_buffer();
      end

      drain();
      if (mismatch_count == 0 && scans_outstanding == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
